@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the top-level RTL file of the core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, checked outside of reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be seen outside of reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    `ASSERT_CLK(lbl, clk, rst_n, !(cond), msg)

`endif

@@ rtl/core/rpsa_pkg.sv @@
// Package with widths, constants and power tables of the modulo 509 scaled add.
package rpsa_pkg;

    localparam int unsigned EXP_W     = 7;
    localparam int unsigned ELEM_W    = 9;
    localparam int unsigned PROD_W    = 18;
    localparam int unsigned QUOT_W    = 10;
    localparam int unsigned MODULUS   = 509;
    localparam logic [31:0] BARRETT_MUL   = 32'd2160140723;
    localparam int unsigned BARRETT_SHIFT = 40;
    localparam int unsigned BARRETT_W     = PROD_W + 32;
    localparam int unsigned NUM_STAGES    = 7;

    typedef logic [ELEM_W-1:0] t_elem;
    typedef logic [PROD_W-1:0] t_prod;
    typedef logic [QUOT_W-1:0] t_quot;
    typedef t_elem t_lo_tab [16];
    typedef t_elem t_hi_tab [8];

    // 16^(2^k) mod 509 for k = 0..6.
    localparam int unsigned BIT_FACTOR [EXP_W] = '{16, 256, 384, 355, 302, 93, 505};

    // Partial power over exponent bits 0..3, reduced.
    function automatic t_lo_tab build_lo_tab();
        t_lo_tab     tab;
        int unsigned acc;
        for (int i = 0; i < 16; i++) begin
            acc = 1;
            for (int k = 0; k < 4; k++) begin
                if (((i >> k) & 1) != 0) begin
                    acc = (acc * BIT_FACTOR[k]) % MODULUS;
                end
            end
            tab[i] = t_elem'(acc);
        end
        return tab;
    endfunction

    // Partial power over exponent bits 4..6, reduced.
    function automatic t_hi_tab build_hi_tab();
        t_hi_tab     tab;
        int unsigned acc;
        for (int i = 0; i < 8; i++) begin
            acc = 1;
            for (int k = 0; k < 3; k++) begin
                if (((i >> k) & 1) != 0) begin
                    acc = (acc * BIT_FACTOR[k+4]) % MODULUS;
                end
            end
            tab[i] = t_elem'(acc);
        end
        return tab;
    endfunction

    localparam t_lo_tab LO_TAB = build_lo_tab();
    localparam t_hi_tab HI_TAB = build_hi_tab();

endpackage

@@ rtl/core/rpsa_if.sv @@
// Valid/ready channel interfaces for the input items and the results.
interface rpsa_in_if import rpsa_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [EXP_W-1:0]     exponent;
    t_elem                addend;
    t_elem                scale;

    modport source (output valid, output exponent, output addend, output scale, input ready);
    modport sink   (input valid, input exponent, input addend, input scale, output ready);
endinterface

interface rpsa_out_if import rpsa_pkg::*; ();
    logic  valid;
    logic  ready;
    t_elem sum_mod;

    modport source (output valid, output sum_mod, input ready);
    modport sink   (input valid, input sum_mod, output ready);
endinterface

@@ rtl/core/restricted_power_scale_add_mod509.sv @@
// Top level: pipelined (addend + scale * 16^exponent) mod 509.
// Each input transfer carries one vector element and gives exactly one result.
// The block takes one element per clock unless the result side stalls; the
// rate is set by the seven-stage pipeline (table lookup, power
// product, two Barrett reduction steps, scaled add, two more Barrett steps),
// with one multiplier in each multiplying stage. Every stage holds its data
// while the stage after it is full and stalled, so empty stages keep filling
// when the result side stalls, and input ready drops only once all stages hold
// an item. There are no configuration registers and no stored state besides
// the pipeline.
`include "assert_macros.svh"

module restricted_power_scale_add_mod509 import rpsa_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rpsa_in_if.sink   i_in,
    rpsa_out_if.source o_out
);

    logic [NUM_STAGES:1] r_vld;
    logic [NUM_STAGES:1] en;

    t_elem r1_lo, r1_hi, r1_add, r1_scl;
    t_prod r2_prod;
    t_elem r2_add, r2_scl;
    t_prod r3_prod;
    t_quot r3_q;
    t_elem r3_add, r3_scl;
    t_elem r4_p, r4_add, r4_scl;
    t_prod r5_t;
    t_prod r6_t;
    t_quot r6_q;
    t_elem r7_sum;

    t_prod                n_prod;
    logic [BARRETT_W-1:0] n_bar3;
    t_elem                n_p;
    logic [PROD_W:0]      n_r4;
    t_prod                n_t;
    logic [BARRETT_W-1:0] n_bar6;
    t_elem                n_sum;
    logic [PROD_W:0]      n_r7;

    // A stage may load when it is empty or its content moves on.
    always_comb begin
        en[NUM_STAGES] = !r_vld[NUM_STAGES] || o_out.ready;
        for (int s = NUM_STAGES - 1; s >= 1; s--) begin
            en[s] = !r_vld[s] || en[s+1];
        end
    end

    assign i_in.ready    = en[1];
    assign o_out.valid   = r_vld[NUM_STAGES];
    assign o_out.sum_mod = r7_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int s = NUM_STAGES; s >= 2; s--) begin
                if (en[s]) begin
                    r_vld[s] <= r_vld[s-1];
                end
            end
            if (en[1]) begin
                r_vld[1] <= i_in.valid;
            end
        end
    end

    // Datapath arithmetic between the stage registers.
    always_comb begin
        n_prod = t_prod'(r1_lo) * t_prod'(r1_hi);
        n_bar3 = BARRETT_W'(r2_prod) * BARRETT_W'(BARRETT_MUL);
        n_r4   = (PROD_W+1)'(r3_prod) - (PROD_W+1)'(r3_q) * (PROD_W+1)'(MODULUS);
        if (n_r4 >= (PROD_W+1)'(MODULUS)) begin
            n_p = t_elem'(n_r4 - (PROD_W+1)'(MODULUS));
        end else begin
            n_p = t_elem'(n_r4);
        end
        n_t    = t_prod'(r4_p) * t_prod'(r4_scl) + t_prod'(r4_add);
        n_bar6 = BARRETT_W'(r5_t) * BARRETT_W'(BARRETT_MUL);
        n_r7   = (PROD_W+1)'(r6_t) - (PROD_W+1)'(r6_q) * (PROD_W+1)'(MODULUS);
        if (n_r7 >= (PROD_W+1)'(MODULUS)) begin
            n_sum = t_elem'(n_r7 - (PROD_W+1)'(MODULUS));
        end else begin
            n_sum = t_elem'(n_r7);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r1_lo  <= LO_TAB[i_in.exponent[3:0]];
            r1_hi  <= HI_TAB[i_in.exponent[EXP_W-1:4]];
            r1_add <= i_in.addend;
            r1_scl <= i_in.scale;
        end
        if (en[2]) begin
            r2_prod <= n_prod;
            r2_add  <= r1_add;
            r2_scl  <= r1_scl;
        end
        if (en[3]) begin
            r3_prod <= r2_prod;
            r3_q    <= n_bar3[BARRETT_SHIFT +: QUOT_W];
            r3_add  <= r2_add;
            r3_scl  <= r2_scl;
        end
        if (en[4]) begin
            r4_p   <= n_p;
            r4_add <= r3_add;
            r4_scl <= r3_scl;
        end
        if (en[5]) begin
            r5_t <= n_t;
        end
        if (en[6]) begin
            r6_t <= r5_t;
            r6_q <= n_bar6[BARRETT_SHIFT +: QUOT_W];
        end
        if (en[7]) begin
            r7_sum <= n_sum;
        end
    end

    `ASSERT_CLK(a_sum_in_range, i_clk, i_rst_n, r_vld[NUM_STAGES] |-> (r7_sum < t_elem'(MODULUS)), "result not reduced below 509")
    `ASSERT_CLK(a_power_unit, i_clk, i_rst_n, r_vld[4] |-> (r4_p != '0 && r4_p < t_elem'(MODULUS)), "power of 16 is zero or not reduced")
    `ASSERT_CLK(a_full_when_blocked, i_clk, i_rst_n, !i_in.ready |-> (&r_vld), "input blocked while a stage is empty")
    `ASSERT_CLK(a_accept_loads, i_clk, i_rst_n, (i_in.valid && i_in.ready) |=> r_vld[1], "accepted transfer not captured")

endmodule
